FILE: sv/c2d_pkg.sv
package c2d_pkg;

  // Build-time defaults for the top-level parameters
  localparam int C2D_MAX_WIDTH   = 32;
  localparam int C2D_SAMPLE_BITS = 16;

  // Fixed geometry and arithmetic
  localparam int KERNEL_SIZE   = 3;
  localparam int TAPS          = KERNEL_SIZE * KERNEL_SIZE;
  localparam int WEIGHT_BITS   = 16;
  localparam int SUM_BITS      = 36;
  localparam int WIDTH_BITS    = 6;
  localparam int CFG_DATA_BITS = KERNEL_SIZE * WEIGHT_BITS;
  localparam int CFG_IDX_BITS  = 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 2'd3;

  localparam int DEFAULT_IMAGE_WIDTH = 32;

  // Queue depths: window queue between front and back, result queue at the output
  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  typedef logic [CFG_DATA_BITS-1:0] kern_row_t;
  typedef kern_row_t [KERNEL_SIZE-1:0] kern_t;

  // Frame control from the register file to the front end
  typedef struct packed {
    logic                  restart;
    logic [WIDTH_BITS-1:0] eff_w;
  } c2d_ctl_t;

  // Window word: last flag in bit 0, then nine taps, row-major, left column first
  function automatic int job_bits(input int sample_bits);
    return TAPS * sample_bits + 1;
  endfunction

endpackage

FILE: sv/c2d_fifo.sv
module c2d_fifo import c2d_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push  = push && (count_r != CNT_W'(DEPTH));
  assign do_pop   = pop && (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  // occupancy
  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/c2d_front.sv
module c2d_front import c2d_pkg::*; #(
  parameter int MAX_WIDTH   = C2D_MAX_WIDTH,
  parameter int SAMPLE_BITS = C2D_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  c2d_ctl_t                             ctl,
  input  logic                                 in_push,
  input  logic signed [SAMPLE_BITS-1:0]        in_pixel,
  output logic                                 in_full,
  input  logic [$clog2(JOB_DEPTH+1)-1:0]       job_count,
  output logic                                 job_push,
  output logic [job_bits(SAMPLE_BITS)-1:0]     job_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = $clog2(MAX_WIDTH + 2);
  localparam int JC_W  = $clog2(JOB_DEPTH + 1);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic                    state_r, state_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [1:0]              slot_r, slot_nxt;
  logic [ROW_W-1:0]        w_row;
  logic [WIDTH_BITS-1:0]   col_inc;
  logic                    credit, real_step, step_go;

  // second step: read data and step attributes
  logic                          s1_valid_r;
  logic                          s1_colz_r, s1_emit_r, s1_last_r;
  logic                          s1_top_ok_r, s1_mid_ok_r;
  logic [1:0]                    s1_top_sel_r, s1_mid_sel_r;
  logic signed [SAMPLE_BITS-1:0] s1_pix_r;

  logic signed [SAMPLE_BITS-1:0] line_mem [3][MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rd_r [3];

  // window, [column][row]; column 2 is the newest
  logic signed [SAMPLE_BITS-1:0] win_r [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [SAMPLE_BITS-1:0] colvec [KERNEL_SIZE];
  logic signed [SAMPLE_BITS-1:0] right_col [KERNEL_SIZE];

  assign w_row = ROW_W'(ctl.eff_w);

  // room in the window queue for this step and the one in flight
  assign credit    = ({1'b0, job_count} + (JC_W+1)'(s1_valid_r)) < (JC_W+1)'(JOB_DEPTH);
  assign in_full   = (state_r != ST_RUN) || !credit;
  assign real_step = (state_r == ST_RUN) && in_push && credit;
  assign step_go   = real_step || ((state_r == ST_FLUSH) && credit);

  // raster position; after the last pixel, w+1 zero steps drain the frame
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    slot_nxt  = slot_r;
    col_inc   = WIDTH_BITS'(col_r) + WIDTH_BITS'(1);
    if (ctl.restart) begin
      state_nxt = ST_RUN;
      row_nxt   = '0;
      col_nxt   = '0;
      slot_nxt  = '0;
    end else if (step_go) begin
      if (col_inc == ctl.eff_w) begin
        col_nxt  = '0;
        row_nxt  = row_r + ROW_W'(1);
        slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      end else begin
        col_nxt = COL_W'(col_inc);
      end
      unique case (state_r)
        ST_RUN: begin
          if (row_nxt == w_row) begin
            state_nxt = ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (row_r == w_row + ROW_W'(1)) begin
            state_nxt = ST_RUN;
            row_nxt   = '0;
            col_nxt   = '0;
            slot_nxt  = '0;
          end
        end
        default: state_nxt = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      row_r      <= '0;
      col_r      <= '0;
      slot_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      slot_r     <= slot_nxt;
      s1_valid_r <= step_go;
    end
  end

  // classify the step: does it complete an output, is it the frame's last
  always_ff @(posedge clk) begin
    if (step_go) begin
      s1_colz_r    <= (col_r == '0);
      s1_emit_r    <= (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
      s1_last_r    <= (row_r == w_row + ROW_W'(1));
      s1_top_ok_r  <= (row_r >= ROW_W'(2));
      s1_mid_ok_r  <= (row_r != '0) && (row_r <= w_row);
      s1_top_sel_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      s1_mid_sel_r <= (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
      s1_pix_r     <= real_step ? in_pixel : '0;
    end
  end

  // line store: one memory per row slot, row r lives in slot r mod 3
  always_ff @(posedge clk) begin
    if (step_go) begin
      for (int s = 0; s < 3; s++) begin
        if (real_step && (slot_r == 2'(s))) begin
          line_mem[s][col_r] <= in_pixel;
        end
        rd_r[s] <= line_mem[s][col_r];
      end
    end
  end

  // new column, rows outside the image read as zero
  always_comb begin
    colvec[0] = s1_top_ok_r ? rd_r[s1_top_sel_r] : '0;
    colvec[1] = s1_mid_ok_r ? rd_r[s1_mid_sel_r] : '0;
    colvec[2] = s1_pix_r;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      right_col[i] = s1_colz_r ? '0 : colvec[i];
    end
  end

  // window word; at column 0 the right edge output closes with a zero column
  always_comb begin
    job_data[0] = s1_last_r;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      job_data[1 + (i*KERNEL_SIZE + 0)*SAMPLE_BITS +: SAMPLE_BITS] = win_r[1][i];
      job_data[1 + (i*KERNEL_SIZE + 1)*SAMPLE_BITS +: SAMPLE_BITS] = win_r[2][i];
      job_data[1 + (i*KERNEL_SIZE + 2)*SAMPLE_BITS +: SAMPLE_BITS] = right_col[i];
    end
  end

  assign job_push = s1_valid_r && s1_emit_r;

  // shift the window; a new row starts with a zero left border
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        win_r[0][i] <= s1_colz_r ? '0 : win_r[1][i];
        win_r[1][i] <= s1_colz_r ? '0 : win_r[2][i];
        win_r[2][i] <= colvec[i];
      end
    end
  end

endmodule

FILE: sv/c2d_back.sv
module c2d_back import c2d_pkg::*; #(
  parameter int SAMPLE_BITS = C2D_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kern_t                            kern,
  input  logic                             job_empty,
  input  logic [job_bits(SAMPLE_BITS)-1:0] job_data,
  output logic                             job_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic signed [SUM_BITS-1:0]       out_conv_sum,
  output logic                             out_last_of_frame
);

  localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
  localparam int EXT_W  = (PROD_W > SUM_BITS) ? PROD_W : SUM_BITS;
  localparam int RC_W   = $clog2(RES_DEPTH + 1);
  localparam int RES_W  = SUM_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] px [TAPS];
  logic signed [WEIGHT_BITS-1:0] wt [TAPS];
  logic signed [PROD_W-1:0]      prod_nxt [TAPS];
  logic signed [PROD_W-1:0]      prod_r [TAPS];
  logic signed [EXT_W-1:0]       prod_ext [TAPS];
  logic [SUM_BITS-1:0]           part_nxt [KERNEL_SIZE];
  logic [SUM_BITS-1:0]           part_r [KERNEL_SIZE];
  logic                          b1_v_r, b2_v_r, last1_r, last2_r;

  logic [RC_W-1:0]  res_count;
  logic [RES_W-1:0] res_wdata, res_rdata;
  logic [SUM_BITS-1:0] total;

  // take a window only when the result queue can hold everything in flight
  assign job_pop = !job_empty &&
                   (({1'b0, res_count} + (RC_W+1)'(b1_v_r) + (RC_W+1)'(b2_v_r))
                    < (RC_W+1)'(RES_DEPTH));

  // nine products, Q8.8 by Q4.12
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        px[i*KERNEL_SIZE + j] =
          $signed(job_data[1 + (i*KERNEL_SIZE + j)*SAMPLE_BITS +: SAMPLE_BITS]);
        wt[i*KERNEL_SIZE + j] = $signed(kern[i][j*WEIGHT_BITS +: WEIGHT_BITS]);
      end
    end
    for (int k = 0; k < TAPS; k++) begin
      prod_nxt[k] = PROD_W'(px[k]) * PROD_W'(wt[k]);
    end
  end

  // row partial sums, wrapping at the result width
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_ext[k] = EXT_W'(prod_r[k]);
    end
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      part_nxt[i] = prod_ext[i*KERNEL_SIZE][SUM_BITS-1:0]
                  + prod_ext[i*KERNEL_SIZE + 1][SUM_BITS-1:0]
                  + prod_ext[i*KERNEL_SIZE + 2][SUM_BITS-1:0];
    end
  end

  assign total     = part_r[0] + part_r[1] + part_r[2];
  assign res_wdata = {total, last2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b1_v_r <= job_pop;
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      prod_r  <= prod_nxt;
      last1_r <= job_data[0];
    end
    if (b1_v_r) begin
      part_r  <= part_nxt;
      last2_r <= last1_r;
    end
  end

  // result queue
  c2d_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b2_v_r),
    .push_data (res_wdata),
    .pop       (out_pop),
    .pop_data  (res_rdata),
    .empty     (out_empty),
    .count     (res_count)
  );

  assign out_conv_sum      = $signed(res_rdata[RES_W-1:1]);
  assign out_last_of_frame = res_rdata[0];

endmodule

FILE: sv/conv2d_3x3_same_padding.sv
// Channel   Ports                                  Word
// input     in_push, in_full, in_pixel             one pixel, raster order
// result    out_pop, out_empty, out_conv_sum,      one output pixel and its
//           out_last_of_frame                      end-of-frame mark
// config    cfg_we, cfg_index, cfg_data            one register write
//
// One pixel a cycle while the queues have room; after a frame's last pixel, w+1 zero
// steps (one a cycle, in_full high) complete its last w+1 windows, one when w is 1.
// A result reaches the ports after the pixel that completes its window, by way of the
// line store read, window queue, product register and partial sum register.
// Synchronous active-low reset clears counters, queues, width (32, capped at MAX_WIDTH),
// weights, not the line store; a stalled result side fills the queues and then raises in_full.
module conv2d_3x3_same_padding import c2d_pkg::*; #(
  parameter int MAX_WIDTH   = C2D_MAX_WIDTH,
  parameter int SAMPLE_BITS = C2D_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [SAMPLE_BITS-1:0] in_pixel,
  output logic                          in_full,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic signed [SUM_BITS-1:0]    out_conv_sum,
  output logic                          out_last_of_frame,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int JOB_W = job_bits(SAMPLE_BITS);
  localparam int JC_W  = $clog2(JOB_DEPTH + 1);
  localparam int DEF_W = (DEFAULT_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEFAULT_IMAGE_WIDTH;

  logic [WIDTH_BITS-1:0] eff_w_r, eff_w_nxt, raw_w;
  kern_t                 kern_r, kern_nxt;
  c2d_ctl_t              ctl;

  logic             job_push, job_pop, job_empty;
  logic [JOB_W-1:0] job_wdata, job_rdata;
  logic [JC_W-1:0]  job_count;

  // register writes; width is clipped to 1..MAX_WIDTH on the way in
  assign raw_w = cfg_data[WIDTH_BITS-1:0];

  always_comb begin
    eff_w_nxt = eff_w_r;
    kern_nxt  = kern_r;
    if (cfg_we) begin
      unique case (cfg_index) inside
        REG_IMAGE_WIDTH: begin
          if (raw_w == '0) begin
            eff_w_nxt = WIDTH_BITS'(1);
          end else if ({1'b0, raw_w} > (WIDTH_BITS+1)'(MAX_WIDTH)) begin
            eff_w_nxt = WIDTH_BITS'(MAX_WIDTH);
          end else begin
            eff_w_nxt = raw_w;
          end
        end
        REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM: begin
          kern_nxt[2'(cfg_index - REG_KERNEL_TOP)] = cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WIDTH_BITS'(DEF_W);
      kern_r  <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      kern_r  <= kern_nxt;
    end
  end

  assign ctl.restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH);
  assign ctl.eff_w   = eff_w_r;

  c2d_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .job_count (job_count),
    .job_push  (job_push),
    .job_data  (job_wdata)
  );

  // window queue between front and back
  c2d_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_wdata),
    .pop       (job_pop),
    .pop_data  (job_rdata),
    .empty     (job_empty),
    .count     (job_count)
  );

  c2d_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .kern              (kern_r),
    .job_empty         (job_empty),
    .job_data          (job_rdata),
    .job_pop           (job_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_conv_sum      (out_conv_sum),
    .out_last_of_frame (out_last_of_frame)
  );

  // the front end never pushes a window into a full queue
  a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && (job_count == JC_W'(JOB_DEPTH))))
    else $error("window queue overflow");

  // a pixel is only taken while the window queue has room
  a_accept_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> (job_count < JC_W'(JOB_DEPTH)))
    else $error("pixel taken without window queue room");

  // a window word that fills the queue is not followed by a push into the full queue
  a_job_push_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && (job_count == JC_W'(JOB_DEPTH - 1)) && job_push && !job_pop)
    |=> !job_push || (job_count != JC_W'(JOB_DEPTH)))
    else $error("window queue credit slip");

endmodule
